// ----- rtl/core/pclk_pkg.sv -----
// shared types, constants and key masking for the pixel code color lookup
package pclk_pkg;

   // sizing
   localparam int TABLE_DEPTH    = 1024;
   localparam int MAX_CODE_CHARS = 8;
   localparam int MAX_WIDTH      = 1024;

   localparam int ADDR_W    = $clog2(TABLE_DEPTH);
   localparam int COUNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int COL_W     = $clog2(MAX_WIDTH + 1);
   localparam int WIDTH_W   = 11;
   localparam int CPP_W     = 4;
   localparam int CODE_W    = 64;
   localparam int COLOR_W   = 32;
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CMP_W     = (COL_W > WIDTH_W) ? COL_W : WIDTH_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARS_PER_PIXEL = 1'b1;

   // item kinds
   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_ENTRY  = 2'd1,
      KIND_PIXEL  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_PIX_OK    = 3'd0,
      ST_BEYOND    = 3'd1,
      ST_SHORT_ROW = 3'd2,
      ST_STORED    = 3'd3,
      ST_DUPLICATE = 3'd4,
      ST_FULL      = 3'd5,
      ST_CLEARED   = 3'd6
   } status_type;

   // table write request
   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  addr;
      logic [CODE_W-1:0]  key;
      logic [COLOR_W-1:0] color;
   } tbl_wr_type;

   // keep the low bytes of the code that the code length selects
   function automatic logic [CODE_W-1:0] key_of(input logic [CODE_W-1:0] code,
                                                input logic [CPP_W-1:0]  cpp);
      logic [CPP_W-1:0]  n;
      logic [CODE_W-1:0] key;
      n = cpp;
      if (n == '0) n = CPP_W'(1);
      if (n > CPP_W'(MAX_CODE_CHARS)) n = CPP_W'(MAX_CODE_CHARS);
      for (int b = 0; b < CODE_W / 8; b++) begin
         key[b*8 +: 8] = (CPP_W'(b) < n) ? code[b*8 +: 8] : 8'h00;
      end
      return key;
   endfunction

endpackage

// ----- rtl/core/pclk_table.sv -----
// entry memory: keys and colors, one write and one registered read per cycle
module pclk_table
   import pclk_pkg::*;
(
   input  logic               clock,
   input  tbl_wr_type         wr,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [CODE_W-1:0]  rd_key,
   output logic [COLOR_W-1:0] rd_color
);

   logic [CODE_W+COLOR_W-1:0] entry_mem_ff [TABLE_DEPTH];
   logic [CODE_W+COLOR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         entry_mem_ff[wr.addr] <= {wr.key, wr.color};
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_key   = rd_data_ff[CODE_W+COLOR_W-1:COLOR_W];
   assign rd_color = rd_data_ff[COLOR_W-1:0];

endmodule

// ----- rtl/core/pixel_code_color_lookup_top.sv -----
// pixel code color lookup: sequencer, key compare, counters and result register
// flow: clear and beyond-width beats pass through S_FINISH to the result register;
//   entry and pixel beats run S_READ, S_CMP per entry compared (0 .. entry_count),
//   then S_RESOLVE and S_FINISH; one beat at a time, next accept from S_IDLE after the
//   result registers; a stalled result register holds the sequencer in its last state
// reset (synchronous, active high): empty table by fill count, width and code length 1
module pixel_code_color_lookup_top
   import pclk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic [CODE_W-1:0]    req_code,
   input  logic [COLOR_W-1:0]   req_color,
   input  logic                 req_row_end,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COLOR_W-1:0]   rsp_pixel_color,
   output logic [2:0]           rsp_status,
   output logic                 rsp_missed,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wr_data
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_READ    = 5'b00010,
      S_CMP     = 5'b00100,
      S_RESOLVE = 5'b01000,
      S_FINISH  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic [CPP_W-1:0]     cpp_ff, cpp_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COLOR_W-1:0]   fallback_ff, fallback_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   kind_type             kind_ff, kind_in;
   logic [CODE_W-1:0]    key_ff, key_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic                 row_end_ff, row_end_in;
   logic                 found_ff, found_in;
   logic [COLOR_W-1:0]   found_color_ff, found_color_in;
   logic [COLOR_W-1:0]   res_color_ff, res_color_in;
   status_type           res_status_ff, res_status_in;
   logic                 res_missed_ff, res_missed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_missed_ff, rsp_missed_in;

   logic [CMP_W-1:0]     width_wide;
   logic [COL_W-1:0]     eff_width;
   logic [COL_W-1:0]     col_plus;
   logic                 scan_last;
   logic                 table_full;
   logic                 store;
   logic [CODE_W-1:0]    rd_key;
   logic [COLOR_W-1:0]   rd_color;
   tbl_wr_type           tbl_wr;

   // table memory
   pclk_table u_table (
      .clock    (clock),
      .wr       (tbl_wr),
      .rd_addr  (idx_ff),
      .rd_key   (rd_key),
      .rd_color (rd_color)
   );

   // clamp the configured width
   assign width_wide = CMP_W'(width_ff);
   assign eff_width  = (width_wide > CMP_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH)
                                                        : COL_W'(width_wide);
   assign col_plus   = col_ff + COL_W'(1);
   assign scan_last  = (COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff;
   assign table_full = count_ff == COUNT_W'(TABLE_DEPTH);
   assign store      = (state_ff == S_RESOLVE) && (kind_ff == KIND_ENTRY) &&
                       !found_ff && !table_full;

   // table write of a new entry at the fill position
   always_comb begin
      tbl_wr.we    = store;
      tbl_wr.addr  = count_ff[ADDR_W-1:0];
      tbl_wr.key   = key_ff;
      tbl_wr.color = color_ff;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      width_in       = width_ff;
      cpp_in         = cpp_ff;
      count_in       = count_ff;
      fallback_in    = fallback_ff;
      col_in         = col_ff;
      idx_in         = idx_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      color_in       = color_ff;
      row_end_in     = row_end_ff;
      found_in       = found_ff;
      found_color_in = found_color_ff;
      res_color_in   = res_color_ff;
      res_status_in  = res_status_ff;
      res_missed_in  = res_missed_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_color_in   = rsp_color_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_missed_in  = rsp_missed_ff;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:     width_in = csr_wr_data[WIDTH_W-1:0];
            CSR_CHARS_PER_PIXEL: cpp_in   = csr_wr_data[CPP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in    = kind_type'(req_kind);
               key_in     = key_of(req_code, cpp_ff);
               color_in   = req_color;
               row_end_in = req_row_end;
               idx_in     = '0;
               case (kind_type'(req_kind))
                  KIND_CLEAR: begin
                     count_in      = '0;
                     fallback_in   = '0;
                     col_in        = '0;
                     res_color_in  = '0;
                     res_status_in = ST_CLEARED;
                     res_missed_in = 1'b0;
                     state_in      = S_FINISH;
                  end
                  KIND_ENTRY, KIND_PIXEL: begin
                     if ((kind_type'(req_kind) == KIND_PIXEL) && (col_ff >= eff_width)) begin
                        res_color_in  = '0;
                        res_status_in = ST_BEYOND;
                        res_missed_in = 1'b0;
                        if (req_row_end) col_in = '0;
                        state_in = S_FINISH;
                     end else if (count_ff == '0) begin
                        found_in = 1'b0;
                        state_in = S_RESOLVE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            // shared key compare against the entry just read
            if (rd_key == key_ff) begin
               found_in       = 1'b1;
               found_color_in = rd_color;
               state_in       = S_RESOLVE;
            end else if (scan_last) begin
               found_in = 1'b0;
               state_in = S_RESOLVE;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = S_READ;
            end
         end
         S_RESOLVE: begin
            res_color_in  = '0;
            res_missed_in = 1'b0;
            if (kind_ff == KIND_ENTRY) begin
               if (found_ff) begin
                  res_status_in = ST_DUPLICATE;
               end else if (table_full) begin
                  res_status_in = ST_FULL;
               end else begin
                  if (count_ff == '0) fallback_in = color_ff;
                  count_in      = count_ff + COUNT_W'(1);
                  res_status_in = ST_STORED;
               end
            end else begin
               res_color_in  = found_ff ? found_color_ff : fallback_ff;
               res_missed_in = !found_ff;
               res_status_in = (row_end_ff && (col_plus < eff_width)) ? ST_SHORT_ROW
                                                                      : ST_PIX_OK;
               col_in        = row_end_ff ? '0 : col_plus;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_color_in  = res_color_ff;
               rsp_status_in = res_status_ff;
               rsp_missed_in = res_missed_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WIDTH_W'(1);
         cpp_ff       <= CPP_W'(1);
         count_ff     <= '0;
         fallback_ff  <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         cpp_ff       <= cpp_in;
         count_ff     <= count_in;
         fallback_ff  <= fallback_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      color_ff       <= color_in;
      row_end_ff     <= row_end_in;
      found_ff       <= found_in;
      found_color_ff <= found_color_in;
      res_color_ff   <= res_color_in;
      res_status_ff  <= res_status_in;
      res_missed_ff  <= res_missed_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_missed_ff  <= rsp_missed_in;
   end

   // ports
   assign req_stall       = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_missed      = rsp_missed_ff;

endmodule

// ----- sim/lookup_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// scoreboard that predicts and checks the results of the pixel code color lookup
package lookup_scoreboard_pkg;
   import pclk_pkg::*;

   // one expected result beat
   typedef struct packed {
      logic [COLOR_W-1:0] pixel_color;
      status_type         status;
      logic               missed;
   } lookup_result_type;

   class lookup_scoreboard;
      logic [WIDTH_W-1:0] image_width;
      logic [CPP_W-1:0]   code_chars;
      logic [CODE_W-1:0]  palette_keys[$];
      logic [COLOR_W-1:0] palette_colors[$];
      logic [COLOR_W-1:0] fallback_color;
      int unsigned        column;
      lookup_result_type  expected_lookups[$];
      int                 errors;

      function new();
         image_width    = WIDTH_W'(1);
         code_chars     = CPP_W'(1);
         fallback_color = '0;
         column         = 0;
         errors         = 0;
      endfunction

      function int pending();
         return expected_lookups.size();
      endfunction

      function int palette_size();
         return palette_keys.size();
      endfunction

      // only the low bytes selected by the code length form the key
      function logic [CODE_W-1:0] masked_code(logic [CODE_W-1:0] code);
         int unsigned n;
         n = code_chars;
         if (n == 0) n = 1;
         if (n > MAX_CODE_CHARS) n = MAX_CODE_CHARS;
         if (n >= 8) return code;
         return code & ((64'd1 << (8 * n)) - 64'd1);
      endfunction

      // first stored entry with this key wins
      function bit find_color(input logic [CODE_W-1:0] key, output logic [COLOR_W-1:0] color);
         color = '0;
         foreach (palette_keys[i]) begin
            if (palette_keys[i] == key) begin
               color = palette_colors[i];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // predict the result of one accepted input beat
      function void note_beat(kind_type kind, logic [CODE_W-1:0] code,
                              logic [COLOR_W-1:0] color, logic row_end);
         lookup_result_type res;
         logic [CODE_W-1:0] key;
         logic [COLOR_W-1:0] hit_color;
         bit hit;
         int unsigned limit;
         res = '0;
         key = masked_code(code);
         hit = find_color(key, hit_color);
         case (kind)
            KIND_CLEAR: begin
               palette_keys.delete();
               palette_colors.delete();
               fallback_color = '0;
               column = 0;
               res.status = ST_CLEARED;
            end
            KIND_ENTRY: begin
               if (hit) res.status = ST_DUPLICATE;
               else if (palette_keys.size() >= TABLE_DEPTH) res.status = ST_FULL;
               else begin
                  if (palette_keys.size() == 0) fallback_color = color;
                  palette_keys.push_back(key);
                  palette_colors.push_back(color);
                  res.status = ST_STORED;
               end
            end
            KIND_PIXEL: begin
               limit = (image_width > MAX_WIDTH) ? MAX_WIDTH : image_width;
               if (column >= limit) res.status = ST_BEYOND;
               else begin
                  if (hit) res.pixel_color = hit_color;
                  else begin
                     res.pixel_color = fallback_color;
                     res.missed = 1'b1;
                  end
                  column++;
                  res.status = (row_end && column < limit) ? ST_SHORT_ROW : ST_PIX_OK;
               end
               if (row_end) column = 0;
            end
            default: return;
         endcase
         expected_lookups.push_back(res);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("lookup mismatch at %0t: %s", $time, what);
      endtask

      // compare one result beat with the oldest prediction
      task check_beat(logic [COLOR_W-1:0] color, logic [2:0] status, logic missed);
         lookup_result_type want;
         if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("result with none pending: color %h status %0d",
                                      color, status));
            return;
         end
         want = expected_lookups.pop_front();
         if (color !== want.pixel_color)
            report_mismatch($sformatf("pixel_color %h, want %h", color, want.pixel_color));
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
         if (missed !== want.missed)
            report_mismatch($sformatf("missed %b, want %b", missed, want.missed));
      endtask
   endclass

endpackage

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top: drives the color lookup with directed and random images and checks every beat
module tb_top;
   import pclk_pkg::*;
   import lookup_scoreboard_pkg::*;

   localparam int RANDOM_BEATS  = 880;
   localparam int SETTLE_CYCLES = 8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_kind = 2'd0;
   logic [CODE_W-1:0]    req_code = '0;
   logic [COLOR_W-1:0]   req_color = '0;
   logic                 req_row_end = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COLOR_W-1:0]   rsp_pixel_color;
   logic [2:0]           rsp_status;
   logic                 rsp_missed;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wr_data = '0;

   lookup_scoreboard  lookups;
   bit                idling_on = 1'b1;
   int unsigned       gap_odds = 4;
   int unsigned       random_beats = 0;
   logic [CODE_W-1:0] image_codes[$];

   pixel_code_color_lookup_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_code        (req_code),
      .req_color       (req_color),
      .req_row_end     (req_row_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_status      (rsp_status),
      .rsp_missed      (rsp_missed),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side stall bursts, with long quiet stretches now and then
   initial begin
      forever begin
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20))
            @(posedge clock);
         if (idling_on && $urandom_range(0, 3) != 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // result beat checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         lookups.check_beat(rsp_pixel_color, rsp_status, rsp_missed);
   end

   // send one input beat, optionally after a gap; valid stays high on return
   task automatic send_beat(kind_type kind, logic [CODE_W-1:0] code,
                            logic [COLOR_W-1:0] color, logic row_end);
      if (idling_on && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_code    <= code;
      req_color   <= color;
      req_row_end <= row_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lookups.note_beat(kind, code, color, row_end);
   endtask

   // stop sending and wait until every predicted beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (lookups.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers; only while the block is idle
   task automatic set_registers(logic [WIDTH_W-1:0] width, logic [CPP_W-1:0] chars);
      logic [CSR_W-1:0] chars_word;
      chars_word = CSR_W'($urandom);
      chars_word[CPP_W-1:0] = chars;
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_IMAGE_WIDTH;
      csr_wr_data <= CSR_W'(width);
      @(posedge clock);
      lookups.image_width = width;
      csr_index   <= CSR_CHARS_PER_PIXEL;
      csr_wr_data <= chars_word;
      @(posedge clock);
      lookups.code_chars = chars;
      csr_wr_en   <= 1'b0;
   endtask

   // keep the key bytes of a code, sometimes filling the unused bytes with junk
   function automatic logic [CODE_W-1:0] pad_code(logic [CODE_W-1:0] code,
                                                  logic [CPP_W-1:0] chars);
      logic [CODE_W-1:0] keep;
      int unsigned n;
      n = (chars == 0) ? 1 : (chars > MAX_CODE_CHARS) ? MAX_CODE_CHARS : chars;
      if (n >= 8 || $urandom_range(0, 1) == 0) return code;
      keep = (64'd1 << (8 * n)) - 64'd1;
      return (code & keep) | ({$urandom, $urandom} & ~keep);
   endfunction

   task automatic send_noise();
      if ($urandom_range(0, 24) == 0)
         send_beat(KIND_UNUSED, {$urandom, $urandom}, $urandom, 1'($urandom));
   endtask

   // one random image: settings, optional clear, colormap, then rows of pixels
   task automatic run_random_image();
      logic [WIDTH_W-1:0] width;
      logic [CPP_W-1:0]   chars;
      logic [CODE_W-1:0]  code;
      int unsigned        pick, limit, row_len;
      bit                 ends;
      drain();
      pick = $urandom_range(0, 19);
      if (pick < 13) width = $urandom_range(1, 6);
      else if (pick < 16) width = $urandom_range(7, 40);
      else if (pick == 16) width = '0;
      else if (pick == 17) width = WIDTH_W'(MAX_WIDTH);
      else width = WIDTH_W'($urandom);
      chars = ($urandom_range(0, 4) == 0) ? CPP_W'($urandom) : CPP_W'($urandom_range(1, 8));
      set_registers(width, chars);
      gap_odds = ($urandom_range(0, 3) == 0) ? 100000 : $urandom_range(1, 6);
      limit = (width > MAX_WIDTH) ? MAX_WIDTH : width;

      // keeping the old table checks keys entered under another code length
      if (lookups.palette_size() > 16 || $urandom_range(0, 5) != 0) begin
         send_beat(KIND_CLEAR, {$urandom, $urandom}, $urandom, 1'($urandom));
         image_codes.delete();
         random_beats++;
      end

      // colormap, some entries repeating an earlier code
      repeat ($urandom_range(1, 12)) begin
         if (image_codes.size() != 0 && $urandom_range(0, 4) == 0)
            code = pad_code(image_codes[$urandom_range(0, image_codes.size() - 1)], chars);
         else
            code = {$urandom, $urandom};
         send_beat(KIND_ENTRY, code, $urandom, 1'($urandom));
         image_codes.push_back(code);
         random_beats++;
         send_noise();
      end

      // rows: mostly full width, some short, long or left open
      repeat ($urandom_range(1, 4)) begin
         pick = $urandom_range(0, 9);
         if (limit == 0) row_len = $urandom_range(1, 3);
         else if (limit > 40) row_len = $urandom_range(1, 12);
         else if (pick < 6) row_len = limit;
         else if (pick < 8) row_len = $urandom_range(1, limit);
         else row_len = limit + $urandom_range(1, 3);
         ends = ($urandom_range(0, 7) != 0);
         for (int i = 0; i < row_len; i++) begin
            if (image_codes.size() != 0 && $urandom_range(0, 4) != 0)
               code = pad_code(image_codes[$urandom_range(0, image_codes.size() - 1)], chars);
            else
               code = {$urandom, $urandom};
            send_beat(KIND_PIXEL, code, $urandom, ends && (i == row_len - 1));
            random_beats++;
            send_noise();
         end
      end
   endtask

   // fill the table to its depth, then hit the full, duplicate and fallback paths
   task automatic fill_table();
      logic [CODE_W-1:0] code, last_code;
      idling_on = 1'b0;
      drain();
      set_registers(WIDTH_W'(3), CPP_W'(8));
      send_beat(KIND_CLEAR, '0, '0, 1'b0);
      last_code = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         code = {$urandom, 32'(i)};
         send_beat(KIND_ENTRY, code, $urandom, 1'b0);
         last_code = code;
      end
      send_beat(KIND_ENTRY, {$urandom, 32'hFFFF_FFFF}, $urandom, 1'b0);
      send_beat(KIND_ENTRY, last_code, $urandom, 1'b0);
      send_beat(KIND_PIXEL, last_code, $urandom, 1'b0);
      send_beat(KIND_PIXEL, {$urandom, 32'hFFFF_FFFE}, $urandom, 1'b1);
      send_beat(KIND_UNUSED, last_code, $urandom, 1'b1);
      send_beat(KIND_CLEAR, '1, '1, 1'b1);
      send_beat(KIND_ENTRY, last_code, $urandom, 1'b0);
      send_beat(KIND_PIXEL, last_code, $urandom, 1'b1);
   endtask

   // main sequence
   initial begin
      lookups = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: width 1, one char per code
      send_beat(KIND_PIXEL, 64'h0, 32'h0, 1'b1);
      send_beat(KIND_UNUSED, '1, '1, 1'b1);
      send_beat(KIND_ENTRY, '1, '1, 1'b0);
      send_beat(KIND_ENTRY, 64'h1234_5678_9ABC_DEFF, 32'h0, 1'b0);
      send_beat(KIND_ENTRY, 64'h0, 32'h0, 1'b1);
      send_beat(KIND_PIXEL, 64'hFFFF_FFFF_FFFF_FF00, 32'h0, 1'b0);
      send_beat(KIND_PIXEL, 64'h55, 32'h0, 1'b0);
      send_beat(KIND_PIXEL, 64'h55, 32'h0, 1'b1);
      send_beat(KIND_PIXEL, 64'h77, 32'h0, 1'b1);

      // zero width, zero code length
      drain();
      set_registers('0, '0);
      send_beat(KIND_PIXEL, 64'h77, 32'h0, 1'b1);
      send_beat(KIND_ENTRY, 64'hA5, 32'h1234_5678, 1'b0);

      // width and code length above their maximum
      drain();
      set_registers('1, '1);
      send_beat(KIND_PIXEL, 64'hA5, 32'h0, 1'b0);
      send_beat(KIND_ENTRY, '1, 32'h0F0F_0F0F, 1'b0);
      send_beat(KIND_PIXEL, '1, 32'h0, 1'b1);
      send_beat(KIND_CLEAR, 64'h0, 32'h0, 1'b0);
      send_beat(KIND_PIXEL, 64'h0, 32'h0, 1'b1);

      // widest row, full code length
      drain();
      set_registers(WIDTH_W'(MAX_WIDTH), CPP_W'(MAX_CODE_CHARS));
      send_beat(KIND_ENTRY, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b0);
      send_beat(KIND_PIXEL, 64'h8000_0000_0000_0001, 32'h0, 1'b1);

      // a row of exactly the width
      drain();
      set_registers(WIDTH_W'(3), CPP_W'(1));
      send_beat(KIND_PIXEL, 64'h01, 32'h0, 1'b0);
      send_beat(KIND_PIXEL, 64'hFF01, 32'h0, 1'b0);
      send_beat(KIND_PIXEL, 64'h02, 32'h0, 1'b1);

      while (random_beats < RANDOM_BEATS) run_random_image();
      fill_table();

      drain();
      repeat (64) @(posedge clock);
      if (lookups.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
